// File: design/rbs_pkg.sv
// Shared types for the repeated block suppressor.
`default_nettype none

package rbs_pkg;

  // Store operations requested by the sequencer for one cycle
  typedef struct packed {
    logic ref_write;   // write the reference window at its fill position
    logic cand_write;  // append a candidate key
    logic shift;       // retire the oldest candidate into the reference
  } store_cmd_t;

  // Register field width of block_length
  localparam int unsigned LenW = 4;

endpackage

`default_nettype wire

// File: design/rbs_key_store.sv
// Reference window and candidate buffer registers with one indexed read port each.
`default_nettype none

module rbs_key_store #(
  parameter int unsigned MAX_BLOCK = 8,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned IdxW      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  wire                   clk_i,
  input  wire rbs_pkg::store_cmd_t cmd_i,
  input  wire  [KEY_WIDTH-1:0]  wr_key_i,
  input  wire  [IdxW-1:0]       ref_wr_idx_i,
  input  wire  [IdxW-1:0]       cand_wr_idx_i,
  input  wire  [IdxW-1:0]       last_idx_i,
  input  wire  [IdxW-1:0]       rd_idx_i,
  output logic [KEY_WIDTH-1:0]  ref_rd_key_o,
  output logic [KEY_WIDTH-1:0]  cand_rd_key_o,
  output logic [KEY_WIDTH-1:0]  cand_head_o
);

  logic [KEY_WIDTH-1:0] ref_q  [MAX_BLOCK];
  logic [KEY_WIDTH-1:0] cand_q [MAX_BLOCK];
  logic [KEY_WIDTH-1:0] ref_up [MAX_BLOCK];
  logic [KEY_WIDTH-1:0] cand_up[MAX_BLOCK];

  // Neighbour one place up, for the shift towards entry 0
  for (genvar g = 0; g < MAX_BLOCK; g++) begin : g_up
    if (g < MAX_BLOCK - 1) begin : g_mid
      assign ref_up[g]  = ref_q[g+1];
      assign cand_up[g] = cand_q[g+1];
    end else begin : g_top
      assign ref_up[g]  = ref_q[g];
      assign cand_up[g] = cand_q[g];
    end
  end

  // Key registers: payload only, no reset
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (cmd_i.ref_write && (IdxW'(j) == ref_wr_idx_i)) begin
        ref_q[j] <= wr_key_i;
      end else if (cmd_i.shift) begin
        if (IdxW'(j) == last_idx_i) begin
          ref_q[j] <= cand_q[0];
        end else if (IdxW'(j) < last_idx_i) begin
          ref_q[j] <= ref_up[j];
        end
      end
      if (cmd_i.cand_write && (IdxW'(j) == cand_wr_idx_i)) begin
        cand_q[j] <= wr_key_i;
      end else if (cmd_i.shift) begin
        cand_q[j] <= cand_up[j];
      end
    end
  end

  // Read ports
  assign ref_rd_key_o  = ref_q[rd_idx_i];
  assign cand_rd_key_o = cand_q[rd_idx_i];
  assign cand_head_o   = cand_q[0];

endmodule

`default_nettype wire

// File: design/rbs_seq.sv
// Sequencer: one shared key comparator stepped over the held candidates, plus output register.
`default_nettype none

module rbs_seq #(
  parameter int unsigned MAX_BLOCK = 8,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned IdxW      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
  parameter int unsigned CntW      = $clog2(MAX_BLOCK + 1)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // input items
  input  wire                        s_valid_i,
  output logic                       s_ready_o,
  input  wire  [KEY_WIDTH-1:0]       s_key_i,
  input  wire                        s_end_i,
  // results
  output logic                       m_valid_o,
  input  wire                        m_ready_i,
  output logic [KEY_WIDTH-1:0]       m_key_o,
  output logic                       m_last_o,
  // block_length writes
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [rbs_pkg::LenW-1:0]   cfg_data_i,
  // store side
  output rbs_pkg::store_cmd_t        cmd_o,
  output logic [IdxW-1:0]            ref_wr_idx_o,
  output logic [IdxW-1:0]            cand_wr_idx_o,
  output logic [IdxW-1:0]            last_idx_o,
  output logic [IdxW-1:0]            rd_idx_o,
  input  wire  [KEY_WIDTH-1:0]       ref_rd_key_i,
  input  wire  [KEY_WIDTH-1:0]       cand_rd_key_i,
  input  wire  [KEY_WIDTH-1:0]       cand_head_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCmp   = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CntW-1:0]      len_q, len_d;
  logic [CntW-1:0]      ref_fill_q, ref_fill_d;
  logic [CntW-1:0]      cand_fill_q, cand_fill_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [KEY_WIDTH-1:0] res_key_q, res_key_d;
  logic                 out_valid_q;
  logic [KEY_WIDTH-1:0] out_key_q;
  logic                 out_last_q;

  logic                 s_acc, cfg_acc, out_free, keys_equal;
  logic [CntW-1:0]      cand_slot, idx_next, len_clamped;
  logic                 load_out, load_last;
  logic [KEY_WIDTH-1:0] load_key;

  // Handshakes: configuration wins over an item offered in the same cycle
  assign s_ready_o   = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign s_acc       = s_valid_i && s_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || m_ready_i;

  // Shared comparator and counter arithmetic
  assign keys_equal = (ref_rd_key_i == cand_rd_key_i);
  assign idx_next   = idx_q + CntW'(1);
  assign cand_slot  = (cand_fill_q >= len_q) ? (len_q - CntW'(1)) : cand_fill_q;

  // Block length: zero reads as one, large values saturate
  always_comb begin
    if (cfg_data_i == '0) begin
      len_clamped = CntW'(1);
    end else if (32'(cfg_data_i) > MAX_BLOCK) begin
      len_clamped = CntW'(MAX_BLOCK);
    end else begin
      len_clamped = CntW'(cfg_data_i);
    end
  end

  // Store addressing
  assign ref_wr_idx_o  = ref_fill_q[IdxW-1:0];
  assign cand_wr_idx_o = cand_slot[IdxW-1:0];
  assign last_idx_o    = IdxW'(len_q - CntW'(1));
  assign rd_idx_o      = idx_q[IdxW-1:0];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ref_fill_d  = ref_fill_q;
    cand_fill_d = cand_fill_q;
    idx_d       = idx_q;
    res_key_d   = res_key_q;
    cmd_o       = '0;
    load_out    = 1'b0;
    load_key    = res_key_q;
    load_last   = 1'b1;
    case (state_q)
      StIdle: begin
        if (cfg_acc) begin
          len_d       = len_clamped;
          ref_fill_d  = '0;
          cand_fill_d = '0;
        end else if (s_acc) begin
          if (s_end_i) begin
            if (cand_fill_q == '0) begin
              ref_fill_d = '0;
            end else begin
              idx_d   = '0;
              state_d = StFlush;
            end
          end else if (ref_fill_q < len_q) begin
            // window still filling: pass the line straight through
            cmd_o.ref_write = 1'b1;
            ref_fill_d      = ref_fill_q + CntW'(1);
            res_key_d       = s_key_i;
            state_d         = StEmit;
          end else begin
            cmd_o.cand_write = 1'b1;
            cand_fill_d      = cand_slot + CntW'(1);
            idx_d            = '0;
            state_d          = StCmp;
          end
        end
      end
      StCmp: begin
        if (!keys_equal) begin
          // mismatch: oldest candidate goes out and into the window
          cmd_o.shift = 1'b1;
          cand_fill_d = cand_fill_q - CntW'(1);
          res_key_d   = cand_head_i;
          state_d     = StEmit;
        end else if (idx_next == cand_fill_q) begin
          // all held keys match; a full block is dropped
          if (cand_fill_q == len_q) begin
            cand_fill_d = '0;
          end
          state_d = StIdle;
        end else begin
          idx_d = idx_next;
        end
      end
      StEmit: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      StFlush: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_key  = cand_rd_key_i;
          load_last = (idx_next == cand_fill_q);
          if (idx_next == cand_fill_q) begin
            ref_fill_d  = '0;
            cand_fill_d = '0;
            state_d     = StIdle;
          end else begin
            idx_d = idx_next;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= CntW'(1);
      ref_fill_q  <= '0;
      cand_fill_q <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ref_fill_q  <= ref_fill_d;
      cand_fill_q <= cand_fill_d;
      idx_q       <= idx_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_key_q <= res_key_d;
    if (load_out) begin
      out_key_q  <= load_key;
      out_last_q <= load_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_key_o   = out_key_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: design/repeated_block_suppressor.sv
// Top level of the repeated block suppressor: stream ports, sequencer and key store.
//
// Channel   Direction  Handshake              Content
// s_axis    in         tvalid/tready          tdata: line_key; tuser: end_of_input
// m_axis    out        tvalid/tready          tdata: out_key; tlast: last_of_run
// cfg       in         cfg_valid/cfg_ready    cfg_data: block_length
//
// While the reference window fills, a line item goes to the emit state; after that it
// steps the single key comparator over the held candidates, plus the emit state when a
// key is passed on. An end-of-input item emits each held key in turn.
// Reset empties both windows and sets block_length to 1.
// Output back-pressure holds the result register; the sequencer waits for it to free.
`default_nettype none

module repeated_block_suppressor #(
  parameter int unsigned MAX_BLOCK = 8,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire  [((KEY_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata_i,  // line_key
  input  wire                                   s_axis_tuser_i,  // end_of_input
  output logic                                  m_axis_tvalid_o,
  input  wire                                   m_axis_tready_i,
  output logic [((KEY_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata_o,  // out_key
  output logic                                  m_axis_tlast_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [rbs_pkg::LenW-1:0]              cfg_data_i
);

  localparam int unsigned DataW = ((KEY_WIDTH + 7) / 8) * 8;
  localparam int unsigned IdxW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCK + 1);

  rbs_pkg::store_cmd_t  cmd;
  logic [IdxW-1:0]      ref_wr_idx, cand_wr_idx, last_idx, rd_idx;
  logic [KEY_WIDTH-1:0] ref_rd_key, cand_rd_key, cand_head, out_key;

  // Sequencer with shared comparator
  rbs_seq #(
    .MAX_BLOCK (MAX_BLOCK),
    .KEY_WIDTH (KEY_WIDTH),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_o     (s_axis_tready_o),
    .s_key_i       (s_axis_tdata_i[KEY_WIDTH-1:0]),
    .s_end_i       (s_axis_tuser_i),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_key_o       (out_key),
    .m_last_o      (m_axis_tlast_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_o         (cmd),
    .ref_wr_idx_o  (ref_wr_idx),
    .cand_wr_idx_o (cand_wr_idx),
    .last_idx_o    (last_idx),
    .rd_idx_o      (rd_idx),
    .ref_rd_key_i  (ref_rd_key),
    .cand_rd_key_i (cand_rd_key),
    .cand_head_i   (cand_head)
  );

  // Reference window and candidate buffer
  rbs_key_store #(
    .MAX_BLOCK (MAX_BLOCK),
    .KEY_WIDTH (KEY_WIDTH),
    .IdxW      (IdxW)
  ) u_store (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .wr_key_i      (s_axis_tdata_i[KEY_WIDTH-1:0]),
    .ref_wr_idx_i  (ref_wr_idx),
    .cand_wr_idx_i (cand_wr_idx),
    .last_idx_i    (last_idx),
    .rd_idx_i      (rd_idx),
    .ref_rd_key_o  (ref_rd_key),
    .cand_rd_key_o (cand_rd_key),
    .cand_head_o   (cand_head)
  );

  // Pad the key to whole bytes
  assign m_axis_tdata_o = DataW'(out_key);

endmodule

`default_nettype wire

// File: design/rbs_checker.sv
// Port-level checks for the repeated block suppressor, bound to the top level.
`default_nettype none

module rbs_checker #(
  parameter int unsigned DataW = 32
) (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              s_axis_tvalid_i,
  input wire              s_axis_tready_o,
  input wire              s_axis_tuser_i,
  input wire              m_axis_tvalid_o,
  input wire              m_axis_tready_i,
  input wire [DataW-1:0]  m_axis_tdata_o,
  input wire              m_axis_tlast_o,
  input wire              cfg_valid_i,
  input wire              cfg_ready_o
);

  // A line request always goes through a compare or emit state before input is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("input ready again straight after a line request");

  // A register write leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> cfg_ready_o)
    else $error("configuration write left the block busy");

  // Never take a line and a register write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !(s_axis_tvalid_i && s_axis_tready_o))
    else $error("line request and register write taken together");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind repeated_block_suppressor rbs_checker #(
  .DataW (((KEY_WIDTH + 7) / 8) * 8)
) u_rbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o)
);

`default_nettype wire
